### sv/cpc_pkg.sv
`timescale 1ns / 1ps
package cpc_pkg;

	localparam int unsigned CoordW = 10;
	localparam int unsigned VertexW = 2 * CoordW;
	localparam int unsigned ParamW = 17;
	localparam int unsigned CountW = 5;
	localparam logic [ParamW-1:0] OneQ16 = 17'h10000;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_CLIP = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EDGE,
		ST_MUL,
		ST_DIV,
		ST_ITP,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic               opcode;
		logic [3:0]         vertex_index;
		logic [CoordW-1:0]  vertex_x;
		logic [CoordW-1:0]  vertex_y;
		logic [CoordW-1:0]  line_x0;
		logic [CoordW-1:0]  line_y0;
		logic [CoordW-1:0]  line_x1;
		logic [CoordW-1:0]  line_y1;
	} request_t;

	typedef struct packed {
		logic               accepted;
		logic [CoordW-1:0]  clip_x0;
		logic [CoordW-1:0]  clip_y0;
		logic [CoordW-1:0]  clip_x1;
		logic [CoordW-1:0]  clip_y1;
		logic [ParamW-1:0]  enter_param;
		logic [ParamW-1:0]  leave_param;
	} result_t;

endpackage

### sv/cpc_ram.sv
`timescale 1ns / 1ps
module cpc_ram #(
	parameter int unsigned Width = 20,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/cpc_divider.sv
`timescale 1ns / 1ps
// Restoring divider: one quotient bit per cycle, quotient = (a << 16) / b.
module cpc_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [21:0] dividend,
	input  logic [21:0] divisor,
	output logic        done,
	output logic [38:0] quotient
);

	localparam int unsigned Steps = 39;

	logic [38:0] num_q;
	logic [22:0] rem_q;
	logic [21:0] div_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [22:0] trial;
	logic [23:0] diff;

	assign trial = {rem_q[21:0], num_q[38]};
	assign diff = {1'b0, trial} - {2'b00, div_q};
	assign quotient = num_q;

	// shift in one bit per step, subtract where it fits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(Steps - 1)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {dividend, 17'd0} >> 1;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			if (!diff[23]) begin
				rem_q <= diff[22:0];
				num_q <= {num_q[37:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[37:0], 1'b0};
			end
		end
	end

endmodule

### sv/convex_polygon_line_clipper.sv
`timescale 1ns / 1ps
// Convex polygon line clipper (Cyrus-Beck).
// Input: raise start with a request while busy is low; the request is taken on
// that edge. A load request (opcode 0) writes one clockwise window vertex into
// the vertex memory and gives no result. A clip request
// (opcode 1) walks the edges 0..n-1 of the window, n being vertex_count clamped
// to 3..MAX_VERTICES, and then raises done for one cycle with the result.
// Per edge: an operand state (ST_EDGE), a multiply state (ST_MUL) and a
// decision state (ST_DIV); an edge that needs a crossing holds the decision
// state while the shared bit-serial divider runs. A memory read state starts
// the walk; interpolating the four clipped coordinates and the done state end
// it. Busy stays high for the whole clip.
// The receiver cannot stall: the result is valid only in the done cycle.
// Configuration: cfg_valid/cfg_ready write vertex_count; ready while idle.
// Reset clears the control state and sets vertex_count to 3; the vertex
// memory is undefined until written.
module convex_polygon_line_clipper #(
	parameter int unsigned MAX_VERTICES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  cpc_pkg::request_t   request,
	output logic                busy,
	output logic                done,
	output cpc_pkg::result_t    result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [cpc_pkg::CountW-1:0] cfg_data
);

	localparam int unsigned IdxW = $clog2(MAX_VERTICES);
	localparam int unsigned CW = cpc_pkg::CoordW;

	cpc_pkg::state_t state_q, state_d;

	logic [cpc_pkg::CountW-1:0] count_q;
	logic [IdxW:0]  n_eff;
	logic [IdxW:0]  edge_q;
	logic           first_q;
	logic [cpc_pkg::VertexW-1:0] vi_q;
	logic [cpc_pkg::VertexW-1:0] rdata;
	logic           we;
	logic [IdxW-1:0] raddr;
	logic signed [CW:0] x0_q, y0_q, dx_q, dy_q;
	logic signed [CW+1:0] ex_s2, ey_s2, rx_s2, ry_s2;
	logic signed [22:0] p1_q, p2_q, p3_q, p4_q;
	logic signed [23:0] num, den;
	logic [16:0] te_q, tl_q;
	logic        rej_q;
	logic        need_div;
	logic        div_start, div_done;
	logic [38:0] quo;
	logic [21:0] div_a, div_b;
	logic [21:0] abs_num, abs_den;
	logic        last_edge;
	logic [1:0]  itp_q;
	logic signed [28:0] itp_mul;
	logic signed [28:0] itp_val;
	logic [CW-1:0] cx0_q, cy0_q, cx1_q, cy1_q;
	logic [16:0] itp_t;
	logic signed [CW:0] itp_c, itp_d;

	// clamp vertex count
	always_comb begin
		if (count_q < 5'd3) begin
			n_eff = (IdxW+1)'(3);
		end else if (32'(count_q) > MAX_VERTICES) begin
			n_eff = (IdxW+1)'(MAX_VERTICES);
		end else begin
			n_eff = (IdxW+1)'(count_q);
		end
	end

	assign cfg_ready = (state_q == cpc_pkg::ST_IDLE);
	assign busy = (state_q != cpc_pkg::ST_IDLE);
	assign we = start && !busy && (request.opcode == cpc_pkg::OP_LOAD)
		&& (32'(request.vertex_index) < MAX_VERTICES);
	assign last_edge = (edge_q + 1'b1 == n_eff);

	// read the far vertex of the current edge; from the multiply on, fetch the
	// far vertex of the next edge (vertex 0 closes the window)
	always_comb begin
		if (state_q == cpc_pkg::ST_IDLE) begin
			raddr = '0;
		end else if (state_q == cpc_pkg::ST_MUL || state_q == cpc_pkg::ST_DIV) begin
			if (edge_q + 2'd2 == n_eff) begin
				raddr = '0;
			end else begin
				raddr = edge_q[IdxW-1:0] + 2'd2;
			end
		end else if (last_edge) begin
			raddr = '0;
		end else begin
			raddr = edge_q[IdxW-1:0] + 1'b1;
		end
	end

	cpc_ram #(.Width(cpc_pkg::VertexW), .Depth(MAX_VERTICES)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (IdxW'(request.vertex_index)),
		.wdata ({request.vertex_y, request.vertex_x}),
		.raddr (raddr),
		.rdata (rdata)
	);

	// edge vectors and offsets from the start point
	always_ff @(posedge clk) begin
		if (state_q == cpc_pkg::ST_EDGE) begin
			ex_s2 <= $signed({2'b0, rdata[CW-1:0]}) - $signed({2'b0, vi_q[CW-1:0]});
			ey_s2 <= $signed({2'b0, rdata[2*CW-1:CW]}) - $signed({2'b0, vi_q[2*CW-1:CW]});
			rx_s2 <= $signed({2'b0, vi_q[CW-1:0]}) - 12'(x0_q);
			ry_s2 <= $signed({2'b0, vi_q[2*CW-1:CW]}) - 12'(y0_q);
		end
	end

	// products
	always_ff @(posedge clk) begin
		if (state_q == cpc_pkg::ST_MUL) begin
			p1_q <= 23'(ey_s2 * rx_s2);
			p2_q <= 23'(ex_s2 * ry_s2);
			p3_q <= 23'(ey_s2 * dx_q);
			p4_q <= 23'(ex_s2 * dy_q);
		end
	end

	assign num = 24'(p1_q) - 24'(p2_q);
	assign den = 24'(p3_q) - 24'(p4_q);
	assign abs_num = num[23] ? 22'(-num) : 22'(num);
	assign abs_den = den[23] ? 22'(-den) : 22'(den);
	assign div_a = abs_num;
	assign div_b = abs_den;
	// divide only where a crossing can move t_enter or t_leave
	assign need_div = (den != 0) && (den[23] == num[23]);
	assign div_start = (state_q == cpc_pkg::ST_DIV) && first_q && need_div;

	cpc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (quo)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cpc_pkg::ST_IDLE: begin
				if (start && request.opcode == cpc_pkg::OP_CLIP) begin
					state_d = cpc_pkg::ST_READ;
				end
			end
			cpc_pkg::ST_READ: state_d = cpc_pkg::ST_EDGE;
			cpc_pkg::ST_EDGE: state_d = cpc_pkg::ST_MUL;
			cpc_pkg::ST_MUL: state_d = cpc_pkg::ST_DIV;
			cpc_pkg::ST_DIV: begin
				if (den == 0 || (!den[23] && num[23]) || (den[23] && !num[23])
					|| div_done) begin
					state_d = last_edge ? cpc_pkg::ST_ITP : cpc_pkg::ST_EDGE;
				end
			end
			cpc_pkg::ST_ITP: begin
				if (itp_q == 2'd3) begin
					state_d = cpc_pkg::ST_OUT;
				end
			end
			cpc_pkg::ST_OUT: state_d = cpc_pkg::ST_IDLE;
			default: state_d = cpc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpc_pkg::ST_IDLE;
			count_q <= 5'd3;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				count_q <= cfg_data;
			end
		end
	end

	// datapath registers of the edge walk
	always_ff @(posedge clk) begin
		unique case (state_q)
			cpc_pkg::ST_IDLE: begin
				edge_q <= '0;
				te_q <= '0;
				tl_q <= cpc_pkg::OneQ16;
				rej_q <= 1'b0;
				itp_q <= '0;
				if (request.line_x0 > request.line_x1) begin
					x0_q <= $signed({1'b0, request.line_x1});
					y0_q <= $signed({1'b0, request.line_y1});
					dx_q <= $signed({1'b0, request.line_x0}) - $signed({1'b0, request.line_x1});
					dy_q <= $signed({1'b0, request.line_y0}) - $signed({1'b0, request.line_y1});
				end else begin
					x0_q <= $signed({1'b0, request.line_x0});
					y0_q <= $signed({1'b0, request.line_y0});
					dx_q <= $signed({1'b0, request.line_x1}) - $signed({1'b0, request.line_x0});
					dy_q <= $signed({1'b0, request.line_y1}) - $signed({1'b0, request.line_y0});
				end
			end
			cpc_pkg::ST_READ: begin
				vi_q <= rdata;
			end
			cpc_pkg::ST_EDGE: begin
				first_q <= 1'b1;
				// far vertex becomes the near vertex of the next edge
				vi_q <= rdata;
			end
			cpc_pkg::ST_MUL: ;
			cpc_pkg::ST_DIV: begin
				first_q <= 1'b0;
				if (den == 0) begin
					if (num[23]) rej_q <= 1'b1;
				end else if (den[23]) begin
					if (!num[23] && num != 0) ;
					// hold crossings beyond the Q1.16 range at all ones so they still reject
					else if (div_done && quo > 39'(te_q)) te_q <= (|quo[38:17]) ? '1 : quo[16:0];
				end else if (num[23]) begin
					rej_q <= 1'b1;
				end else if (div_done && quo < 39'(tl_q)) begin
					tl_q <= quo[16:0];
				end
				if (state_d != cpc_pkg::ST_DIV) begin
					edge_q <= edge_q + 1'b1;
				end
			end
			cpc_pkg::ST_ITP: begin
				itp_q <= itp_q + 2'd1;
				unique case (itp_q)
					2'd0: cx0_q <= itp_val[16+CW-1:16];
					2'd1: cy0_q <= itp_val[16+CW-1:16];
					2'd2: cx1_q <= itp_val[16+CW-1:16];
					default: cy1_q <= itp_val[16+CW-1:16];
				endcase
			end
			default: ;
		endcase
	end

	// one multiply per interpolated coordinate
	always_comb begin
		itp_t = itp_q[1] ? tl_q : te_q;
		itp_c = itp_q[0] ? y0_q : x0_q;
		itp_d = itp_q[0] ? dy_q : dx_q;
		itp_mul = 29'(itp_d * $signed({1'b0, itp_t}));
		itp_val = {itp_c, 16'd0} + itp_mul;
		if (itp_val[28]) itp_val = '0;
	end

	// result strobe
	always_comb begin
		done = (state_q == cpc_pkg::ST_OUT);
		result = '0;
		if (done && !rej_q && te_q <= tl_q) begin
			result.accepted = 1'b1;
			result.clip_x0 = cx0_q;
			result.clip_y0 = cy0_q;
			result.clip_x1 = cx1_q;
			result.clip_y1 = cy1_q;
			result.enter_param = te_q;
			result.leave_param = tl_q;
		end
	end

endmodule
